@@ sv/pps_pkg.sv @@
// shared types, constants and field widths of the priority scheduler
package pps_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int TIME_BITS  = 24;
    localparam int PRIO_BITS  = 16;
    localparam int BURST_BITS = 16;
    localparam int QUANT_BITS = 16;
    localparam int SUM_BITS   = ((TIME_BITS > QUANT_BITS) ? TIME_BITS : QUANT_BITS) + 1;

    // fixed field widths on the stream ports
    localparam int SLOT_FIELD_BITS = 4;
    localparam int TIME_FIELD_BITS = 24;
    localparam int CMD_BITS        = 2;
    localparam int S_TDATA_BITS    = 64;
    localparam int M_TDATA_BITS    = 128;
    localparam int M_TUSER_BITS    = 3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic step_start;
        logic scan_en;
        logic update_en;
        logic calc_en;
        logic emit_en;
    } pps_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } pps_status_t;

endpackage

@@ sv/pps_ctrl.sv @@
// sequencing state machine of the priority scheduler
module pps_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pps_pkg::CMD_BITS-1:0]  s_cmd,
    input  pps_pkg::pps_status_t          status,
    output pps_pkg::pps_ctrl_t            ctrl
);
    import pps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_CALC   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctrl.load       = accept && (cmd_t'(s_cmd) == CMD_LOAD);
        ctrl.clear      = accept && (cmd_t'(s_cmd) == CMD_CLEAR);
        ctrl.step_start = accept && (cmd_t'(s_cmd) == CMD_STEP);
        ctrl.scan_en    = (state_reg == ST_SCAN);
        ctrl.update_en  = (state_reg == ST_UPDATE);
        ctrl.calc_en    = (state_reg == ST_CALC);
        ctrl.emit_en    = (state_reg == ST_EMIT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.step_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_CALC;
            ST_CALC:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_step_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step_start |=> state_reg == ST_SCAN)
        else $error("step transfer did not start a scan");
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && status.scan_last |=> state_reg == ST_UPDATE)
        else $error("scan did not end after the last slot");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit_en |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after emitting");
`endif

endmodule

@@ sv/pps_dp.sv @@
// task tables, time base, winner search and result register of the scheduler
module pps_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              quantum_wr_en,
    input  logic [pps_pkg::QUANT_BITS-1:0]    quantum_wr_data,
    input  logic [pps_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  pps_pkg::pps_ctrl_t                ctrl,
    output pps_pkg::pps_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pps_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic [pps_pkg::M_TUSER_BITS-1:0]  m_tuser
);
    import pps_pkg::*;

    // input fields
    logic [SLOT_FIELD_BITS-1:0] in_slot;
    logic [PRIO_BITS-1:0]       in_prio;
    logic [TIME_FIELD_BITS-1:0] in_arrival;
    logic [BURST_BITS-1:0]      in_burst;
    logic [SLOT_BITS-1:0]       in_idx;
    logic                       in_slot_ok;

    // task tables
    logic [PRIO_BITS-1:0]  prio_mem    [SLOTS];
    logic [TIME_BITS-1:0]  arrival_mem [SLOTS];
    logic [BURST_BITS-1:0] burst_mem   [SLOTS];
    logic [BURST_BITS-1:0] remain_mem  [SLOTS];
    logic [TIME_BITS-1:0]  fstart_mem  [SLOTS];
    logic [SLOTS-1:0]      pending_reg;
    logic [SLOTS-1:0]      started_reg;

    logic [TIME_BITS-1:0]  now_reg;
    logic [QUANT_BITS-1:0] quantum_reg;

    // search state
    logic [SLOT_BITS-1:0]  scan_idx_reg;
    logic [SLOT_BITS-1:0]  win_reg;
    logic [PRIO_BITS-1:0]  win_prio_reg;
    logic                  found_reg;
    logic                  any_reg;
    logic                  better;

    // update and report
    logic [QUANT_BITS-1:0] q_eff;
    logic [BURST_BITS-1:0] rem_w;
    logic [BURST_BITS-1:0] run;
    logic [SUM_BITS-1:0]   now_sum;
    logic [TIME_BITS-1:0]  now_sat;
    logic                  fin_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [TIME_BITS-1:0]  ta_reg;
    logic [TIME_BITS-1:0]  resp_reg;
    logic [TIME_BITS-1:0]  wt;
    logic                  done_now;

    // result register
    logic                       m_tvalid_reg;
    logic                       idle_reg;
    logic                       done_reg;
    logic                       all_done_reg;
    logic [SLOT_FIELD_BITS-1:0] ran_slot_reg;
    logic [TIME_FIELD_BITS-1:0] slice_start_reg;
    logic [TIME_FIELD_BITS-1:0] completion_reg;
    logic [TIME_FIELD_BITS-1:0] turnaround_reg;
    logic [TIME_FIELD_BITS-1:0] waiting_reg;
    logic [TIME_FIELD_BITS-1:0] response_reg;

    assign in_slot    = s_tdata[3:0];
    assign in_prio    = s_tdata[19:4];
    assign in_arrival = s_tdata[43:20];
    assign in_burst   = s_tdata[59:44];
    assign in_idx     = SLOT_BITS'(in_slot);
    assign in_slot_ok = (32'(in_slot) < SLOTS);

    assign status.scan_last = (scan_idx_reg == SLOT_BITS'(SLOTS - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // quantum register, zero acts as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANT_BITS'(1);
        end
        else if (quantum_wr_en)
        begin
            quantum_reg <= quantum_wr_data;
        end
    end

    assign q_eff = (quantum_reg == '0) ? QUANT_BITS'(1) : quantum_reg;

    // slot compare during the scan
    assign better = pending_reg[scan_idx_reg]
                 && (arrival_mem[scan_idx_reg] <= now_reg)
                 && (!found_reg || (prio_mem[scan_idx_reg] > win_prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
        end
        else if (ctrl.step_start)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
        end
        else if (ctrl.scan_en)
        begin
            if (!status.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_BITS'(1);
            end
            if (pending_reg[scan_idx_reg])
            begin
                any_reg <= 1'b1;
            end
            if (better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_en && better)
        begin
            win_reg      <= scan_idx_reg;
            win_prio_reg <= prio_mem[scan_idx_reg];
        end
    end

    // slice length and saturating time advance
    assign rem_w   = remain_mem[win_reg];
    assign run     = (rem_w < BURST_BITS'(q_eff)) ? rem_w : BURST_BITS'(q_eff);
    assign now_sum = SUM_BITS'(now_reg)
                   + (found_reg ? SUM_BITS'(run) : SUM_BITS'(q_eff));
    assign now_sat = (now_sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(now_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            pending_reg <= '0;
            started_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            now_reg     <= '0;
            pending_reg <= '0;
            started_reg <= '0;
        end
        else if (ctrl.load)
        begin
            if (in_slot_ok)
            begin
                pending_reg[in_idx] <= 1'b1;
                started_reg[in_idx] <= 1'b0;
            end
        end
        else if (ctrl.update_en && any_reg)
        begin
            now_reg <= now_sat;
            if (found_reg)
            begin
                started_reg[win_reg] <= 1'b1;
                if (rem_w == run)
                begin
                    pending_reg[win_reg] <= 1'b0;
                end
            end
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (ctrl.load && in_slot_ok)
        begin
            prio_mem[in_idx]    <= in_prio;
            arrival_mem[in_idx] <= TIME_BITS'(in_arrival);
            burst_mem[in_idx]   <= in_burst;
            remain_mem[in_idx]  <= in_burst;
        end
        else if (ctrl.update_en && any_reg && found_reg)
        begin
            remain_mem[win_reg] <= rem_w - run;
            if (!started_reg[win_reg])
            begin
                fstart_mem[win_reg] <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update_en)
        begin
            start_reg <= now_reg;
            fin_reg   <= found_reg && (rem_w == run);
        end
        if (ctrl.calc_en)
        begin
            ta_reg   <= now_reg - arrival_mem[win_reg];
            resp_reg <= fstart_mem[win_reg] - arrival_mem[win_reg];
        end
    end

    // waiting clamps at zero
    assign wt = (SUM_BITS'(ta_reg) > SUM_BITS'(burst_mem[win_reg]))
              ? TIME_BITS'(SUM_BITS'(ta_reg) - SUM_BITS'(burst_mem[win_reg]))
              : '0;
    assign done_now = any_reg && found_reg && fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.emit_en)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_en)
        begin
            all_done_reg    <= !any_reg;
            idle_reg        <= any_reg && !found_reg;
            done_reg        <= done_now;
            ran_slot_reg    <= (any_reg && found_reg) ? SLOT_FIELD_BITS'(win_reg) : '0;
            slice_start_reg <= any_reg ? TIME_FIELD_BITS'(start_reg) : '0;
            completion_reg  <= done_now ? TIME_FIELD_BITS'(now_reg) : '0;
            turnaround_reg  <= done_now ? TIME_FIELD_BITS'(ta_reg) : '0;
            waiting_reg     <= done_now ? TIME_FIELD_BITS'(wt) : '0;
            response_reg    <= done_now ? TIME_FIELD_BITS'(resp_reg) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, response_reg, waiting_reg, turnaround_reg,
                       completion_reg, slice_start_reg, ran_slot_reg};
    assign m_tuser  = {all_done_reg, done_reg, idle_reg};

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit_en |-> (!m_tvalid_reg || m_tready))
        else $error("result written over an untaken result");
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update_en && any_reg && found_reg && (rem_w == run) && !ctrl.clear
        |=> !pending_reg[$past(win_reg)])
        else $error("finished slot still pending");
    a_all_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && all_done_reg |-> !done_reg && !idle_reg)
        else $error("all_done combined with another flag");
`endif

endmodule

@@ sv/preemptive_priority_scheduler_unit.sv @@
// top level of the preemptive priority scheduler
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: cmd; tdata: slot, priority, arrival, burst
// m_*       out  m_tvalid/m_tready    tuser: idle, done_res, all_done; tdata: times
// quantum   in   quantum_wr_en        quantum_wr_data, write only
//
// load and clear commands take effect on acceptance; a step runs through these states:
// accept, one slot per cycle through the priority scan,
// then update, time arithmetic and the result write
// the scan walks the task table one slot at a time
// a result waits in the output register while the next transfer is taken;
// a step only stalls in its emit state if that register is still full
// reset (rst_n low, async) empties the table, zeros time and sets quantum to 1
module preemptive_priority_scheduler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // quantum register
    input  logic                              quantum_wr_en,
    input  logic [pps_pkg::QUANT_BITS-1:0]    quantum_wr_data,
    // command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pps_pkg::S_TDATA_BITS-1:0]  s_tdata,   // slot, task_priority, arrival, burst, pad
    input  logic [pps_pkg::CMD_BITS-1:0]      s_tuser,   // cmd
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pps_pkg::M_TDATA_BITS-1:0]  m_tdata,   // ran_slot, slice_start, completion,
                                                         // turnaround, waiting, response, pad
    output logic [pps_pkg::M_TUSER_BITS-1:0]  m_tuser    // idle, done_res, all_done
);
    import pps_pkg::*;

    pps_ctrl_t   ctrl;
    pps_status_t status;

    // state machine: accepts transfers and sequences the step
    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .status   (status),
        .ctrl     (ctrl)
    );

    // tables, time base, winner search and output register
    pps_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .quantum_wr_en   (quantum_wr_en),
        .quantum_wr_data (quantum_wr_data),
        .s_tdata         (s_tdata),
        .ctrl            (ctrl),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

@@ dv/preemptive_priority_scheduler_unit_tb.sv @@
// self-checking testbench for the preemptive priority scheduler unit
module preemptive_priority_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int ITEM_TARGET   = 1450;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 30;   // covers a load or clear still in flight

    // command transfer payload, lowest field declared last
    typedef struct packed {
        logic [3:0]                 pad;
        logic [BURST_BITS-1:0]      burst;
        logic [TIME_FIELD_BITS-1:0] arrival;
        logic [PRIO_BITS-1:0]       prio;
        logic [SLOT_FIELD_BITS-1:0] slot;
    } task_word_t;

    // result transfer payload, lowest field declared last
    typedef struct packed {
        logic [3:0]                 pad;
        logic [TIME_FIELD_BITS-1:0] response;
        logic [TIME_FIELD_BITS-1:0] waiting;
        logic [TIME_FIELD_BITS-1:0] turnaround;
        logic [TIME_FIELD_BITS-1:0] completion;
        logic [TIME_FIELD_BITS-1:0] slice_start;
        logic [SLOT_FIELD_BITS-1:0] ran_slot;
    } report_word_t;

    typedef struct packed {
        logic all_done;
        logic done_res;
        logic idle;
    } report_flags_t;

    typedef struct packed {
        cmd_t       cmd;
        task_word_t word;
    } sched_cmd_t;

    typedef struct packed {
        report_flags_t flags;
        report_word_t  word;
    } sched_result_t;

    // dut ports, all inputs known from time zero
    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    quantum_wr_en   = 1'b0;
    logic [QUANT_BITS-1:0]   quantum_wr_data = '0;
    logic                    s_tvalid        = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata         = '0;   // slot, task_priority, arrival, burst, pad
    logic [CMD_BITS-1:0]     s_tuser         = '0;   // cmd
    logic                    m_tvalid;
    logic                    m_tready        = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;   // ran_slot, slice_start, completion, turnaround,
                                        // waiting, response, pad
    logic [M_TUSER_BITS-1:0] m_tuser;   // idle, done_res, all_done

    preemptive_priority_scheduler_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .quantum_wr_en   (quantum_wr_en),
        .quantum_wr_data (quantum_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

    always #10 clk = ~clk;

    // scheduler state as the testbench sees it
    logic                  task_live  [SLOTS] = '{default: 1'b0};
    logic                  task_began [SLOTS] = '{default: 1'b0};
    logic [PRIO_BITS-1:0]  prio_of    [SLOTS];
    logic [TIME_BITS-1:0]  arrive_at  [SLOTS];
    logic [BURST_BITS-1:0] burst_of   [SLOTS];
    logic [BURST_BITS-1:0] left_of    [SLOTS];
    logic [TIME_BITS-1:0]  began_at   [SLOTS];
    logic [TIME_BITS-1:0]  clock_now   = '0;
    logic [QUANT_BITS-1:0] quantum_reg = 16'd1;

    sched_cmd_t    cmd_feed[$];      // commands waiting for the driver
    sched_result_t due_results[$];   // scheduling decisions not yet seen on the output

    int   fed     = 0;   // commands queued, no-ops not counted
    int   fails   = 0;
    int   s_gap   = 0;
    int   m_stall = 0;
    bit   calm    = 1'b0;   // no idling on either side
    logic s_taken = 1'b0;   // command transfer at the last rising edge

    // time plus a slice, held at the top of the time range
    function automatic logic [TIME_BITS-1:0] sat_time(input logic [TIME_BITS-1:0] t,
                                                      input logic [QUANT_BITS-1:0] d);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(t) + SUM_BITS'(d);
        return (sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // apply one accepted command, queue the decision a step produces
    task automatic schedule_command(input sched_cmd_t c);
        sched_result_t         r;
        int                    win;
        int                    s;
        logic                  found;
        logic [QUANT_BITS-1:0] qe;
        logic [BURST_BITS-1:0] run;
        logic [TIME_BITS-1:0]  ta;
        r     = '0;
        win   = -1;
        found = 1'b0;
        s     = int'(c.word.slot);
        case (c.cmd)
            CMD_LOAD:
            begin
                // a busy slot is simply overwritten and starts over
                task_live[s]  = 1'b1;
                task_began[s] = 1'b0;
                prio_of[s]    = c.word.prio;
                arrive_at[s]  = c.word.arrival;
                burst_of[s]   = c.word.burst;
                left_of[s]    = c.word.burst;
                began_at[s]   = '0;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    task_live[i]  = 1'b0;
                    task_began[i] = 1'b0;
                end
                clock_now = '0;
            end
            CMD_STEP:
            begin
                // strictly greater keeps the lowest slot on a priority tie
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (task_live[i])
                    begin
                        found = 1'b1;
                        if (arrive_at[i] <= clock_now &&
                            (win < 0 || prio_of[i] > prio_of[win]))
                            win = i;
                    end
                end
                if (!found)
                    r.flags.all_done = 1'b1;   // time holds still
                else
                begin
                    qe = (quantum_reg == '0) ? 16'd1 : quantum_reg;
                    r.word.slice_start = clock_now;
                    if (win < 0)
                    begin
                        r.flags.idle = 1'b1;
                        clock_now    = sat_time(clock_now, qe);
                    end
                    else
                    begin
                        if (!task_began[win])
                        begin
                            task_began[win] = 1'b1;
                            began_at[win]   = clock_now;
                        end
                        // a zero burst runs an empty slice and finishes now
                        run            = (left_of[win] < qe) ? left_of[win] : qe;
                        clock_now      = sat_time(clock_now, run);
                        left_of[win]   = left_of[win] - run;
                        r.word.ran_slot = SLOT_FIELD_BITS'(win);
                        if (left_of[win] == '0)
                        begin
                            ta                = clock_now - arrive_at[win];
                            task_live[win]    = 1'b0;
                            r.flags.done_res  = 1'b1;
                            r.word.completion = clock_now;
                            r.word.turnaround = ta;
                            // saturated time can leave turnaround below the burst
                            r.word.waiting    = (ta > TIME_BITS'(burst_of[win]))
                                              ? ta - TIME_BITS'(burst_of[win]) : '0;
                            r.word.response   = began_at[win] - arrive_at[win];
                        end
                    end
                end
                due_results.insert(due_results.size(), r);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic string show(input sched_result_t r);
        return $sformatf({"idle=%0d slot=%0d start=%0h done=%0d cpl=%0h ta=%0h wait=%0h ",
                          "rsp=%0h all_done=%0d"},
                         r.flags.idle, r.word.ran_slot, r.word.slice_start, r.flags.done_res,
                         r.word.completion, r.word.turnaround, r.word.waiting,
                         r.word.response, r.flags.all_done);
    endfunction

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= 10)
            $display("%s", msg);
    endtask

    task automatic feed(input cmd_t c, input int unsigned slot,
                        input int unsigned prio,
                        input int unsigned arr,
                        input int unsigned burst);
        sched_cmd_t it;
        it              = '0;
        it.cmd          = c;
        it.word.slot    = SLOT_FIELD_BITS'(slot);
        it.word.prio    = PRIO_BITS'(prio);
        it.word.arrival = TIME_FIELD_BITS'(arr);
        it.word.burst   = BURST_BITS'(burst);
        cmd_feed.insert(cmd_feed.size(), it);
        if (c != CMD_NOP)
            fed++;
    endtask

    // a step ignores its payload, so the payload is random
    task automatic feed_step();
        feed(CMD_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // wait until no command is queued or in flight and every decision came back
    task automatic settle();
        while (cmd_feed.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // prediction and checking, both on the rising edge
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        s_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (quantum_wr_en)
                quantum_reg = quantum_wr_data;
            if (s_tvalid && s_tready)
                schedule_command({cmd_t'(s_tuser), task_word_t'(s_tdata)});
            if (m_tvalid && m_tready)
            begin
                got.flags = m_tuser;
                got.word  = m_tdata;
                if (due_results.size() == 0)
                    note_failure({"result transfer with nothing expected: ", show(got)});
                else
                begin
                    want = due_results.pop_front();
                    if (got.flags.idle        !== want.flags.idle        ||
                        got.flags.done_res    !== want.flags.done_res    ||
                        got.flags.all_done    !== want.flags.all_done    ||
                        got.word.ran_slot     !== want.word.ran_slot     ||
                        got.word.slice_start  !== want.word.slice_start  ||
                        got.word.completion   !== want.word.completion   ||
                        got.word.turnaround   !== want.word.turnaround   ||
                        got.word.waiting      !== want.word.waiting      ||
                        got.word.response     !== want.word.response)
                        note_failure($sformatf("result mismatch at %0t\n  expected %s\n  actual   %s",
                                               $realtime, show(want), show(got)));
                end
            end
        end
    end

    // command driver: holds a transfer until taken, idles in random bursts
    always @(negedge clk)
    begin
        sched_cmd_t nxt;
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (s_gap > 0)
            begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (!calm && cmd_feed.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                s_gap    <= $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end
            else if (cmd_feed.size() != 0)
            begin
                nxt      = cmd_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.word;
                s_tuser  <= nxt.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver: stalls in random bursts, and is ready again between two bursts
    always @(negedge clk)
    begin
        if (m_stall > 0)
        begin
            m_stall  <= m_stall - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && m_tready && $urandom_range(0, 7) == 0)
        begin
            m_stall  <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        int unsigned q_list [PHASES];
        int          qe;
        int          n;
        int          steps;
        int          far;
        int          spread;
        int          phase_end;
        int          s1;
        int unsigned arr;
        int unsigned burst;

        // largest, zero (acts as one), small ones, a mid range, a small one to finish
        q_list = '{16'hFFFF, 0, 1, 2, 3, $urandom_range(4, 12), $urandom_range(13, 4000),
                   $urandom_range(1, 8)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under the reset quantum of one
        feed_step();                                    // empty table reports all done
        feed(CMD_LOAD, 0, 16'h0000, 0, 0);              // zero burst, lowest priority
        feed(CMD_LOAD, 15, 16'hFFFF, 0, 2);
        feed(CMD_LOAD, 3, 16'hFFFF, 0, 1);              // ties with slot 15, lower slot wins
        feed(CMD_LOAD, 7, 16'd100, 5, 1);
        feed(CMD_LOAD, 7, 16'd200, 2, 1);               // busy slot overwritten
        feed(CMD_LOAD, 9, 16'd5, 7, 1);                 // late arrival forces idle slices
        feed_step();
        feed_step();
        feed(CMD_LOAD, 15, 16'hFFFF, 1, 1);             // task that already ran starts over
        repeat (9) feed_step();
        feed(CMD_NOP, 4'hF, 16'hFFFF, 32'(TIME_MAX), 16'hFFFF);   // no-op command does nothing
        feed(CMD_CLEAR, 0, 0, 0, 0);
        feed_step();
        feed(CMD_LOAD, 15, 16'h8000, 32'(TIME_MAX), 16'hFFFF);    // never ready before saturation
        feed_step();
        feed(CMD_CLEAR, 4'hF, 16'hFFFF, 32'(TIME_MAX), 16'hFFFF);
        feed_step();

        for (int p = 0; p < PHASES; p++)
        begin
            // quantum only changes while the block is idle
            settle();
            @(negedge clk);
            quantum_wr_en   <= 1'b1;
            quantum_wr_data <= QUANT_BITS'(q_list[p]);
            @(negedge clk);
            quantum_wr_en   <= 1'b0;
            qe   = (q_list[p] == 0) ? 1 : q_list[p];
            calm = (p == PHASES - 1);

            if (p == 0)
            begin
                // walk time up to saturation: a max burst finishing past the top,
                // then a task that arrives at the last time value
                s1  = $urandom_range(0, 15);
                arr = 24'hFF0000 + $urandom_range(0, 16'hFF00);
                feed(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
                feed(CMD_LOAD, s1, $urandom, arr, 16'hFFFF);
                feed(CMD_LOAD, s1 ^ 1, 16'h0000, 32'(TIME_MAX), $urandom_range(0, 5));
                repeat (arr / qe + 5) feed_step();
            end

            phase_end = fed + (ITEM_TARGET - fed) / (PHASES - p);
            while (fed < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // noise: any command with any payload
                    repeat ($urandom_range(1, 5))
                        feed(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                             $urandom);
                end
                else
                begin
                    // a task set sized to the quantum, then enough steps to drain it
                    spread = qe * 8;
                    steps  = 0;
                    far    = 0;
                    if ($urandom_range(0, 4) != 0)
                        feed(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        arr   = $urandom_range(0, spread);
                        burst = $urandom_range(0, (qe * 4 > 65535) ? 65535 : qe * 4);
                        // narrow priorities make ties common
                        feed(CMD_LOAD, $urandom,
                             $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom,
                             arr, burst);
                        steps += (burst + qe - 1) / qe + 1;
                        if (arr > far)
                            far = arr;
                    end
                    steps += far / qe + 2;
                    if ($urandom_range(0, 5) == 0)
                        steps = $urandom_range(0, steps);   // left unfinished on purpose
                    repeat (steps)
                    begin
                        // late loads preempt or overwrite running tasks
                        if ($urandom_range(0, 11) == 0)
                            feed(CMD_LOAD, $urandom, $urandom, $urandom_range(0, spread),
                                 $urandom_range(0, (qe * 2 > 65535) ? 65535 : qe * 2));
                        feed_step();
                    end
                end
            end
        end

        settle();
        if (fails == 0)
            $display("preemptive_priority_scheduler_unit test passed");
        else
            $display("preemptive_priority_scheduler_unit test failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("preemptive_priority_scheduler_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pps_pkg.sv
sv/pps_ctrl.sv
sv/pps_dp.sv
sv/preemptive_priority_scheduler_unit.sv
dv/preemptive_priority_scheduler_unit_tb.sv
